// File: hdl/i2da_pkg.sv
// i2da_pkg: shared constants and types for the int64 to decimal ASCII unit.
// No dependencies; imported by the top level, its port checker and the testbench.
`default_nettype none

package i2da_pkg;

    // Input value width and the decimal digit store (BCD, 4 bits per digit)
    localparam int unsigned MAG_W      = 64;
    localparam int unsigned DIGITS     = 20;
    localparam int unsigned BCD_W      = 4 * DIGITS;
    localparam int unsigned BIT_CNT_W  = $clog2(MAG_W);
    localparam int unsigned DIG_CNT_W  = $clog2(DIGITS + 1);
    localparam int unsigned CHAR_W     = 6;

    // Character codes, truncated to the 6-bit character word
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage : i2da_pkg

`default_nettype wire

// File: hdl/int64_to_decimal_ascii_unit.sv
// int64_to_decimal_ascii_unit: signed 64-bit integer to decimal ASCII text.
// Depends on i2da_pkg (constants, state type).
//
// Usage:
//   Command side: drive number and pulse start; the word is taken at a rising
//   edge where start is high and busy is low. busy stays high until the last
//   character of the text has been issued.
//   Result side: one character per strobe cycle, most significant first, a
//   leading '-' for negative values, no leading zeros, last_char on the final
//   character. The receiver cannot stall; every strobe cycle is one word.
// Timing:
//   Shift-add-3 conversion (one bit of the magnitude per cycle through a single
//   BCD adjust-and-shift unit), then dropping leading zero digits and finding the
//   first digit, then emitting the characters (n digits, plus '-' if negative); each
//   character shows on the ports the cycle after it is formed. The next word may
//   be started in the cycle the last character is shown.
// Reset: rst_n low clears the sequencer and the strobe; the unit is idle after.
`default_nettype none

module int64_to_decimal_ascii_unit
    import i2da_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [MAG_W-1:0]  number,
    output logic                          strobe,
    output logic             [CHAR_W-1:0] ascii_char,
    output logic                          last_char
);

    state_t                 state_reg,     state_next;
    logic [MAG_W-1:0]       mag_reg,       mag_next;
    logic [BCD_W-1:0]       bcd_reg,       bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg,   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg,   dig_cnt_next;
    logic                   neg_reg,       neg_next;
    logic                   strobe_reg,    strobe_next;
    logic [CHAR_W-1:0]      char_reg,      char_next;
    logic                   last_reg,      last_next;

    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic                   dig_one;

    // Shared adjust unit: add 3 to every BCD digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign dig_one   = (dig_cnt_reg == DIG_CNT_W'(1));

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next     = number[MAG_W-1];
                    // Unsigned magnitude; the most negative value maps to 2^63
                    mag_next     = number[MAG_W-1] ? (~$unsigned(number) + MAG_W'(1))
                                                   : $unsigned(number);
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = DIG_CNT_W'(DIGITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(MAG_W - 1))
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && !dig_one)
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_EMIT;
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_MINUS;
                last_next   = 1'b0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next  = 1'b1;
                char_next    = ASCII_ZERO + {2'b00, top_digit};
                last_next    = dig_one;
                bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                if (dig_one)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

endmodule : int64_to_decimal_ascii_unit

`default_nettype wire

// File: hdl/i2da_checker.sv
// i2da_checker: port-level checks for int64_to_decimal_ascii_unit, plus bind.
// Depends on i2da_pkg (character codes); sees the top level's ports only.
`default_nettype none

module i2da_checker
    import i2da_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              strobe,
    input wire logic [CHAR_W-1:0] ascii_char,
    input wire logic              last_char
);

    // Accepted command makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepted command");

    // Only '-' or a digit is ever shown
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (ascii_char == ASCII_MINUS) ||
                   (ascii_char >= ASCII_ZERO && ascii_char <= ASCII_NINE))
        else $error("character word out of range");

    // A minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ascii_char == ASCII_MINUS) |-> !last_char)
        else $error("minus sign flagged as last character");

    // Text ends before the next conversion finishes: gap after last character
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !strobe)
        else $error("character word right after last character");

    // No character word in the first busy cycle
    a_no_strobe_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !strobe)
        else $error("character word at start of conversion");

endmodule : i2da_checker

bind int64_to_decimal_ascii_unit i2da_checker u_i2da_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char)
);

`default_nettype wire

// File: bench/int64_to_decimal_ascii_unit_tb.sv
// Testbench for int64_to_decimal_ascii_unit: drives signed 64-bit words and checks
// every decimal character against a built-in digit predictor.
// Depends on i2da_pkg and the unit itself; needs no files or arguments.
`timescale 1ns / 100ps

module int64_to_decimal_ascii_unit_tb
    import i2da_pkg::*;
();

    // One expected character of a rendered number
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    // One pending command word and the sender idle rate it goes out with
    typedef struct {
        logic [MAG_W-1:0] value;
        int unsigned      idle_pct;
    } number_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [MAG_W-1:0] number = '0;
    logic                    busy;
    logic                    strobe;
    logic [CHAR_W-1:0]       ascii_char;
    logic                    last_char;

    number_word_t number_q[$];
    char_word_t   text_exp[$];
    logic         word_taken = 1'b0;
    int unsigned  err_count = 0;

    int unsigned  phase_idle[4] = '{0, 84, 0, 9};

    int64_to_decimal_ascii_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number     (number),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // Decimal text of one word: optional '-', digits MSB first, last flagged
    function automatic void predict_text(input logic [MAG_W-1:0] value);
        logic [MAG_W-1:0] mag;
        logic [3:0]       dig [DIGITS];
        int               nd;
        int               k;
        char_word_t       w;
        mag = value[MAG_W-1] ? (~value + 64'd1) : value;
        nd = 0;
        do
        begin
            dig[nd] = 4'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
        end
        while (mag != 0 && nd < DIGITS);
        if (value[MAG_W-1])
        begin
            w.ch   = ASCII_MINUS;
            w.last = 1'b0;
            text_exp.push_back(w);
        end
        for (k = nd - 1; k >= 0; k--)
        begin
            w.ch   = ASCII_ZERO + CHAR_W'(dig[k]);
            w.last = (k == 0);
            text_exp.push_back(w);
        end
    endfunction

    // Random word: full 64-bit noise, or a random digit count with random sign
    function automatic logic [MAG_W-1:0] random_number();
        logic [MAG_W-1:0] raw;
        logic [MAG_W-1:0] lim;
        int               d;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
        begin
            d = $urandom_range(1, 19);
            if ($urandom_range(7) == 0)
                d = 1;
            lim = 64'd1;
            repeat (d) lim = lim * 64'd10;
            raw = raw % lim;
            if ($urandom_range(1) == 1)
                raw = -raw;
        end
        return raw;
    endfunction

    task automatic add_word(input logic [MAG_W-1:0] value, input int unsigned idle_pct);
        number_word_t item;
        item.value    = value;
        item.idle_pct = idle_pct;
        number_q.push_back(item);
    endtask

    // Driver: present the next word at the falling edge once the last one was taken
    always @(negedge clk)
    begin : drive_words
        number_word_t item;
        logic         go;
        if (!rst_n)
        begin
            start  <= 1'b0;
            number <= '0;
        end
        else if (!start || word_taken)
        begin
            go = 1'b0;
            if (number_q.size() != 0 && $urandom_range(99) >= number_q[0].idle_pct)
            begin
                item = number_q.pop_front();
                go   = 1'b1;
            end
            if (go)
            begin
                start  <= 1'b1;
                number <= item.value;
            end
            else
            begin
                start  <= 1'b0;
                number <= {$urandom, $urandom};
            end
        end
    end

    // Monitor: predict on accept, check each strobed character in order
    always @(posedge clk)
    begin : watch_text
        char_word_t want;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= start && !busy;
            if (start && !busy)
                predict_text(number);
            if (strobe)
            begin
                if (text_exp.size() == 0)
                    report_mismatch($sformatf("unexpected character %0d", ascii_char));
                else
                begin
                    want = text_exp.pop_front();
                    if (ascii_char !== want.ch)
                        report_mismatch($sformatf("ascii_char %0d, want %0d",
                                                  ascii_char, want.ch));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, want %0b",
                                                  last_char, want.last));
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : run_test
        int i;
        // directed: zero, small values, digit-count boundaries, extremes
        add_word(64'd0, 0);
        add_word(64'd1, 0);
        add_word(-64'd1, 0);
        add_word(64'd9, 0);
        add_word(64'd10, 0);
        add_word(-64'd9, 9);
        add_word(-64'd10, 9);
        add_word(64'd99, 0);
        add_word(64'd100, 0);
        add_word(64'd999_999_999, 84);
        add_word(64'd1_000_000_000, 0);
        add_word(64'd999_999_999_999_999_999, 0);
        add_word(64'd1_000_000_000_000_000_000, 0);
        add_word(-64'd1_000_000_000_000_000_000, 9);
        add_word(64'h7FFF_FFFF_FFFF_FFFF, 0);
        add_word(64'h8000_0000_0000_0000, 0);
        add_word(64'h8000_0000_0000_0001, 0);
        add_word(64'h8000_0000_0000_0000, 84);
        add_word(64'h7FFF_FFFF_FFFF_FFFE, 0);
        add_word(64'hAAAA_AAAA_AAAA_AAAA, 0);
        add_word(64'h5555_5555_5555_5555, 0);
        add_word(64'd0, 84);
        // random, in four idle phases
        for (i = 0; i < 228; i++)
            add_word(random_number(), phase_idle[i / 57]);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (number_q.size() != 0 || start)
            @(posedge clk);
        while (text_exp.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/i2da_pkg.sv
hdl/int64_to_decimal_ascii_unit.sv
hdl/i2da_checker.sv
bench/int64_to_decimal_ascii_unit_tb.sv
